[sv/cpat_pkg.sv]
package cpat_pkg;

   localparam int MAP_W         = 64;
   localparam int FRAME_FIELD_W = 55;
   localparam int WORD_SHIFT    = 6;
   localparam int BITMAP_W      = 22;
   localparam int IDX_W         = 8;
   localparam int PAGE_AGE_W    = 8;
   localparam int COUNT_W       = 32;
   localparam int STATUS_W      = 3;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [BITMAP_W-1:0] BITMAP_RESET = '1;
   localparam logic                OP_READ      = 1'b1;

   typedef enum logic [2:0] {
      K_IDLE,
      K_ACTIVE,
      K_SKIP,
      K_BAD,
      K_READ,
      K_READ_NONE
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_IDLE   = 3'd0,
      ST_ACTIVE = 3'd1,
      ST_SKIP   = 3'd2,
      ST_BAD    = 3'd3,
      ST_READ   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      B_CLEAR,
      B_IDLE,
      B_READ_WAIT,
      B_AGE_WAIT,
      B_OLD_WAIT,
      B_NEW_RD,
      B_NEW_WAIT
   } back_state_type;

endpackage

[sv/cpat_ram.sv]
module cpat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/cpat_front.sv]
module cpat_front #(
   parameter int FRAME_BITS = 16,
   parameter int AGE_BITS   = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_op,
   input  logic [cpat_pkg::MAP_W-1:0]        req_map_entry,
   input  logic [cpat_pkg::MAP_W-1:0]        req_idle_word,
   input  logic [cpat_pkg::IDX_W-1:0]        req_bucket_index,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cpat_pkg::BITMAP_W-1:0]     csr_data,
   input  logic                              q_full,
   input  logic                              clearing,
   output logic                              push,
   output cpat_pkg::kind_type                push_kind,
   output logic [FRAME_BITS-1:0]             push_frame,
   output logic [AGE_BITS-1:0]               push_bkt
);

   import cpat_pkg::*;

   localparam int WIDX_W = FRAME_FIELD_W - WORD_SHIFT;

   logic [BITMAP_W-1:0]      bitmap_words_ff;
   logic [BITMAP_W-1:0]      bitmap_words_in;
   logic [FRAME_FIELD_W-1:0] frame_full;
   logic [WIDX_W-1:0]        word_idx;
   logic                     beyond_bitmap;
   logic                     beyond_table;
   logic                     idle_bit;
   logic                     read_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         bitmap_words_ff <= BITMAP_RESET;
      end else begin
         bitmap_words_ff <= bitmap_words_in;
      end
   end

   assign csr_ready       = 1'b1;
   assign bitmap_words_in = (csr_valid && csr_ready) ? csr_data : bitmap_words_ff;

   assign busy = q_full || clearing;
   assign push = start && !busy;

   assign frame_full    = req_map_entry[FRAME_FIELD_W-1:0];
   assign word_idx      = frame_full[FRAME_FIELD_W-1:WORD_SHIFT];
   assign beyond_bitmap = ((word_idx >> BITMAP_W) != '0)
                          || (word_idx[BITMAP_W-1:0] >= bitmap_words_ff);
   assign beyond_table  = (frame_full >> FRAME_BITS) != '0;
   assign idle_bit      = req_idle_word[frame_full[WORD_SHIFT-1:0]];
   assign read_ok       = (32'(req_bucket_index) >> AGE_BITS) == 32'd0;

   assign push_frame = FRAME_BITS'(frame_full);
   assign push_bkt   = AGE_BITS'(req_bucket_index);

   always_comb begin
      if (req_op == OP_READ) begin
         push_kind = read_ok ? K_READ : K_READ_NONE;
      end else if (frame_full == '0) begin
         push_kind = K_SKIP;
      end else if (beyond_bitmap || beyond_table) begin
         push_kind = K_BAD;
      end else if (idle_bit) begin
         push_kind = K_IDLE;
      end else begin
         push_kind = K_ACTIVE;
      end
   end

endmodule

[sv/cpat_queue.sv]
module cpat_queue #(
   parameter int FRAME_BITS = 16,
   parameter int AGE_BITS   = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  cpat_pkg::kind_type    push_kind,
   input  logic [FRAME_BITS-1:0] push_frame,
   input  logic [AGE_BITS-1:0]   push_bkt,
   output logic                  full,
   output logic                  q_valid,
   input  logic                  pop,
   output cpat_pkg::kind_type    q_kind,
   output logic [FRAME_BITS-1:0] q_frame,
   output logic [AGE_BITS-1:0]   q_bkt
);

   import cpat_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   kind_type              kind_q_ff  [QUEUE_DEPTH];
   logic [FRAME_BITS-1:0] frame_q_ff [QUEUE_DEPTH];
   logic [AGE_BITS-1:0]   bkt_q_ff   [QUEUE_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff;
   logic [PTR_W-1:0]      wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff;
   logic [PTR_W-1:0]      rd_ptr_in;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;

   assign full    = count_ff == CNT_W'(QUEUE_DEPTH);
   assign q_valid = count_ff != '0;
   assign q_kind  = kind_q_ff[rd_ptr_ff];
   assign q_frame = frame_q_ff[rd_ptr_ff];
   assign q_bkt   = bkt_q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         kind_q_ff[wr_ptr_ff]  <= push_kind;
         frame_q_ff[wr_ptr_ff] <= push_frame;
         bkt_q_ff[wr_ptr_ff]   <= push_bkt;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("item pushed into full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_valid)
      else $error("item popped from empty queue");

endmodule

[sv/cpat_back.sv]
module cpat_back #(
   parameter int FRAME_BITS = 16,
   parameter int AGE_BITS   = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_valid,
   output logic                                pop,
   input  cpat_pkg::kind_type                  q_kind,
   input  logic [FRAME_BITS-1:0]               q_frame,
   input  logic [AGE_BITS-1:0]                 q_bkt,
   output logic                                clearing,
   output logic                                rsp_valid,
   output logic [cpat_pkg::STATUS_W-1:0]       rsp_status,
   output logic [cpat_pkg::PAGE_AGE_W-1:0]     rsp_page_age,
   output logic [cpat_pkg::COUNT_W-1:0]        rsp_bucket_count
);

   import cpat_pkg::*;

   localparam int CLR_BITS = (FRAME_BITS > AGE_BITS) ? FRAME_BITS : AGE_BITS;
   localparam logic [AGE_BITS-1:0] AGE_MAX = '1;
   localparam logic [COUNT_W-1:0]  CNT_MAX = '1;

   back_state_type        state_ff;
   back_state_type        state_in;
   logic [CLR_BITS-1:0]   clr_ff;
   logic [CLR_BITS-1:0]   clr_in;
   logic [FRAME_BITS-1:0] frame_ff;
   logic [FRAME_BITS-1:0] frame_in;
   logic [AGE_BITS-1:0]   old_ff;
   logic [AGE_BITS-1:0]   old_in;
   logic [AGE_BITS-1:0]   new_ff;
   logic [AGE_BITS-1:0]   new_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   status_type            rsp_status_ff;
   status_type            rsp_status_in;
   logic [PAGE_AGE_W-1:0] rsp_page_age_ff;
   logic [PAGE_AGE_W-1:0] rsp_page_age_in;
   logic [COUNT_W-1:0]    rsp_count_ff;
   logic [COUNT_W-1:0]    rsp_count_in;

   logic                  age_wr_en;
   logic [FRAME_BITS-1:0] age_wr_addr;
   logic [AGE_BITS-1:0]   age_wr_data;
   logic                  age_rd_en;
   logic [FRAME_BITS-1:0] age_rd_addr;
   logic [AGE_BITS-1:0]   age_rd_data;
   logic                  bkt_wr_en;
   logic [AGE_BITS-1:0]   bkt_wr_addr;
   logic [COUNT_W-1:0]    bkt_wr_data;
   logic                  bkt_rd_en;
   logic [AGE_BITS-1:0]   bkt_rd_addr;
   logic [COUNT_W-1:0]    bkt_rd_data;
   logic [AGE_BITS-1:0]   age_next;
   logic [COUNT_W-1:0]    cnt_inc;

   cpat_ram #(
      .WIDTH (AGE_BITS),
      .DEPTH (2 ** FRAME_BITS)
   ) u_age_ram (
      .clock   (clock),
      .wr_en   (age_wr_en),
      .wr_addr (age_wr_addr),
      .wr_data (age_wr_data),
      .rd_en   (age_rd_en),
      .rd_addr (age_rd_addr),
      .rd_data (age_rd_data)
   );

   cpat_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (2 ** AGE_BITS)
   ) u_bucket_ram (
      .clock   (clock),
      .wr_en   (bkt_wr_en),
      .wr_addr (bkt_wr_addr),
      .wr_data (bkt_wr_data),
      .rd_en   (bkt_rd_en),
      .rd_addr (bkt_rd_addr),
      .rd_data (bkt_rd_data)
   );

   assign age_next = (age_rd_data == AGE_MAX) ? AGE_MAX : age_rd_data + AGE_BITS'(1);
   assign cnt_inc  = (bkt_rd_data == CNT_MAX) ? CNT_MAX : bkt_rd_data + COUNT_W'(1);

   always_comb begin
      state_in        = state_ff;
      clr_in          = clr_ff;
      frame_in        = frame_ff;
      old_in          = old_ff;
      new_in          = new_ff;
      rsp_valid_in    = 1'b0;
      rsp_status_in   = rsp_status_ff;
      rsp_page_age_in = rsp_page_age_ff;
      rsp_count_in    = rsp_count_ff;
      pop             = 1'b0;
      age_wr_en       = 1'b0;
      age_wr_addr     = frame_ff;
      age_wr_data     = '0;
      age_rd_en       = 1'b0;
      age_rd_addr     = q_frame;
      bkt_wr_en       = 1'b0;
      bkt_wr_addr     = old_ff;
      bkt_wr_data     = '0;
      bkt_rd_en       = 1'b0;
      bkt_rd_addr     = q_bkt;

      unique case (state_ff)
         B_CLEAR: begin
            age_wr_en   = 1'b1;
            age_wr_addr = FRAME_BITS'(clr_ff);
            bkt_wr_en   = 1'b1;
            bkt_wr_addr = AGE_BITS'(clr_ff);
            clr_in      = clr_ff + CLR_BITS'(1);
            if (clr_ff == '1) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (q_valid) begin
               pop             = 1'b1;
               frame_in        = q_frame;
               rsp_page_age_in = '0;
               rsp_count_in    = '0;
               unique case (q_kind)
                  K_SKIP: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_SKIP;
                  end
                  K_BAD: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_BAD;
                  end
                  K_ACTIVE: begin
                     age_wr_en     = 1'b1;
                     age_wr_addr   = q_frame;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_ACTIVE;
                  end
                  K_READ_NONE: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_READ;
                  end
                  K_READ: begin
                     bkt_rd_en = 1'b1;
                     state_in  = B_READ_WAIT;
                  end
                  K_IDLE: begin
                     age_rd_en = 1'b1;
                     state_in  = B_AGE_WAIT;
                  end
                  default: begin
                     state_in = B_IDLE;
                  end
               endcase
            end
         end
         B_READ_WAIT: begin
            rsp_valid_in    = 1'b1;
            rsp_status_in   = ST_READ;
            rsp_page_age_in = '0;
            rsp_count_in    = bkt_rd_data;
            state_in        = B_IDLE;
         end
         B_AGE_WAIT: begin
            old_in      = age_rd_data;
            new_in      = age_next;
            age_wr_en   = 1'b1;
            age_wr_data = age_next;
            bkt_rd_en   = 1'b1;
            if (age_rd_data != '0) begin
               bkt_rd_addr = age_rd_data;
               state_in    = B_OLD_WAIT;
            end else begin
               bkt_rd_addr = age_next;
               state_in    = B_NEW_WAIT;
            end
         end
         B_OLD_WAIT: begin
            bkt_wr_en   = 1'b1;
            bkt_wr_addr = old_ff;
            bkt_wr_data = (bkt_rd_data != '0) ? bkt_rd_data - COUNT_W'(1) : '0;
            state_in    = B_NEW_RD;
         end
         B_NEW_RD: begin
            bkt_rd_en   = 1'b1;
            bkt_rd_addr = new_ff;
            state_in    = B_NEW_WAIT;
         end
         B_NEW_WAIT: begin
            bkt_wr_en       = 1'b1;
            bkt_wr_addr     = new_ff;
            bkt_wr_data     = cnt_inc;
            rsp_valid_in    = 1'b1;
            rsp_status_in   = ST_IDLE;
            rsp_page_age_in = PAGE_AGE_W'(new_ff);
            rsp_count_in    = cnt_inc;
            state_in        = B_IDLE;
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff        <= frame_in;
      old_ff          <= old_in;
      new_ff          <= new_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_page_age_ff <= rsp_page_age_in;
      rsp_count_ff    <= rsp_count_in;
   end

   assign clearing         = state_ff == B_CLEAR;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_page_age     = rsp_page_age_ff;
   assign rsp_bucket_count = rsp_count_ff;

   a_quiet_while_clearing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_CLEAR) |-> (!rsp_valid_ff && !pop))
      else $error("activity during clearing pass");

   a_idle_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_IDLE)) |-> (rsp_bucket_count != '0))
      else $error("idle page counted into empty bucket");

   a_idle_age_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_NEW_WAIT) |-> (new_ff != '0))
      else $error("idle page with zero new age");

endmodule

[sv/cold_page_age_tracker_top.sv]
// results: skipped, bad, active and out-of-range reads pass the queue and result registers;
// bucket reads add B_READ_WAIT, age-zero idle pages B_AGE_WAIT and B_NEW_WAIT, other idle pages
// B_AGE_WAIT, B_OLD_WAIT, B_NEW_RD and B_NEW_WAIT; the back end takes a new item only in B_IDLE,
// after its age/bucket read-modify-write sequence on single-port-read memories; a 2-entry queue
// lets the front take items meanwhile; reset: busy while both tables are cleared
// results cannot be stalled; rsp_valid marks each result for one cycle
module cold_page_age_tracker_top #(
   parameter int FRAME_BITS = 16,
   parameter int AGE_BITS   = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_op,
   input  logic [cpat_pkg::MAP_W-1:0]        req_map_entry,
   input  logic [cpat_pkg::MAP_W-1:0]        req_idle_word,
   input  logic [cpat_pkg::IDX_W-1:0]        req_bucket_index,
   output logic                              rsp_valid,
   output logic [cpat_pkg::STATUS_W-1:0]     rsp_status,
   output logic [cpat_pkg::PAGE_AGE_W-1:0]   rsp_page_age,
   output logic [cpat_pkg::COUNT_W-1:0]      rsp_bucket_count,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cpat_pkg::BITMAP_W-1:0]     csr_data
);

   import cpat_pkg::*;

   logic                  q_full;
   logic                  clearing;
   logic                  push;
   kind_type              push_kind;
   logic [FRAME_BITS-1:0] push_frame;
   logic [AGE_BITS-1:0]   push_bkt;
   logic                  q_valid;
   logic                  pop;
   kind_type              q_kind;
   logic [FRAME_BITS-1:0] q_frame;
   logic [AGE_BITS-1:0]   q_bkt;

   cpat_front #(
      .FRAME_BITS (FRAME_BITS),
      .AGE_BITS   (AGE_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_map_entry    (req_map_entry),
      .req_idle_word    (req_idle_word),
      .req_bucket_index (req_bucket_index),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data),
      .q_full           (q_full),
      .clearing         (clearing),
      .push             (push),
      .push_kind        (push_kind),
      .push_frame       (push_frame),
      .push_bkt         (push_bkt)
   );

   cpat_queue #(
      .FRAME_BITS (FRAME_BITS),
      .AGE_BITS   (AGE_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_kind  (push_kind),
      .push_frame (push_frame),
      .push_bkt   (push_bkt),
      .full       (q_full),
      .q_valid    (q_valid),
      .pop        (pop),
      .q_kind     (q_kind),
      .q_frame    (q_frame),
      .q_bkt      (q_bkt)
   );

   cpat_back #(
      .FRAME_BITS (FRAME_BITS),
      .AGE_BITS   (AGE_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .pop              (pop),
      .q_kind           (q_kind),
      .q_frame          (q_frame),
      .q_bkt            (q_bkt),
      .clearing         (clearing),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_page_age     (rsp_page_age),
      .rsp_bucket_count (rsp_bucket_count)
   );

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;
   import cpat_pkg::*;

   localparam int FRAME_BITS   = 16;
   localparam int AGE_BITS     = 8;
   localparam int TABLE_DEPTH  = 1 << FRAME_BITS;
   localparam int BUCKET_DEPTH = 1 << AGE_BITS;
   localparam int AGE_MAX      = BUCKET_DEPTH - 1;
   localparam int DRAIN_CYCLES = 10;
   localparam int PHASE_ITEMS  = 280;
   localparam logic OP_OBSERVE = 1'b0;

   typedef struct {
      status_type          status;
      logic [PAGE_AGE_W-1:0] page_age;
      logic [COUNT_W-1:0]  count;
   } page_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_op = OP_OBSERVE;
   logic [MAP_W-1:0]      req_map_entry = '0;
   logic [MAP_W-1:0]      req_idle_word = '0;
   logic [IDX_W-1:0]      req_bucket_index = '0;
   logic                  rsp_valid;
   logic [STATUS_W-1:0]   rsp_status;
   logic [PAGE_AGE_W-1:0] rsp_page_age;
   logic [COUNT_W-1:0]    rsp_bucket_count;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [BITMAP_W-1:0]   csr_data = '0;

   logic [AGE_BITS-1:0]   frame_age [TABLE_DEPTH];
   logic [COUNT_W-1:0]    age_count [BUCKET_DEPTH];
   logic [BITMAP_W-1:0]   words_limit;
   page_result_type       pending_results [$];
   int                    hot_frames [12];
   int                    errors = 0;
   int                    checked = 0;
   int                    idle_updates = 0;
   int                    oldest_age = 0;
   int                    gap_pct = 0;

   always #6 clock = ~clock;

   cold_page_age_tracker_top #(
      .FRAME_BITS(FRAME_BITS),
      .AGE_BITS  (AGE_BITS)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_map_entry   (req_map_entry),
      .req_idle_word   (req_idle_word),
      .req_bucket_index(req_bucket_index),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_page_age    (rsp_page_age),
      .rsp_bucket_count(rsp_bucket_count),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data)
   );

   initial begin
      foreach (frame_age[i]) frame_age[i] = '0;
      foreach (age_count[i]) age_count[i] = '0;
      words_limit = BITMAP_RESET;
   end

   task automatic update_age_histogram(input logic op, input logic [MAP_W-1:0] entry,
                                       input logic [MAP_W-1:0] word,
                                       input logic [IDX_W-1:0] index);
      page_result_type r;
      logic [FRAME_FIELD_W-1:0] frame;
      int old_age;
      int new_age;
      r.status   = ST_READ;
      r.page_age = '0;
      r.count    = '0;
      frame      = entry[FRAME_FIELD_W-1:0];
      if (op == OP_READ) begin
         r.count = (index < BUCKET_DEPTH) ? age_count[index] : '0;
      end else if (frame == 0) begin
         r.status = ST_SKIP;
      end else if ((frame >> WORD_SHIFT) >= words_limit || frame >= TABLE_DEPTH) begin
         r.status = ST_BAD;
      end else if (!word[frame[5:0]]) begin
         frame_age[frame[FRAME_BITS-1:0]] = '0;
         r.status = ST_ACTIVE;
      end else begin
         old_age = int'(frame_age[frame[FRAME_BITS-1:0]]);
         if (old_age != 0 && age_count[old_age] != 0) age_count[old_age]--;
         new_age = (old_age >= AGE_MAX) ? AGE_MAX : old_age + 1;
         frame_age[frame[FRAME_BITS-1:0]] = AGE_BITS'(new_age);
         if (age_count[new_age] != '1) age_count[new_age]++;
         r.status   = ST_IDLE;
         r.page_age = PAGE_AGE_W'(new_age);
         r.count    = age_count[new_age];
         idle_updates++;
         if (new_age > oldest_age) oldest_age = new_age;
      end
      pending_results.push_back(r);
   endtask

   // called and returns at a falling edge
   task automatic send_item(input logic op, input logic [MAP_W-1:0] entry,
                            input logic [MAP_W-1:0] word, input logic [IDX_W-1:0] index);
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
         @(negedge clock);
      end
      start            <= 1'b1;
      req_op           <= op;
      req_map_entry    <= entry;
      req_idle_word    <= word;
      req_bucket_index <= index;
      do @(posedge clock); while (busy !== 1'b0);
      update_age_histogram(op, entry, word, index);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_bitmap_words(input logic [BITMAP_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      words_limit = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [MAP_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic observe(input logic [MAP_W-1:0] entry, input logic [MAP_W-1:0] word);
      send_item(OP_OBSERVE, entry, word, IDX_W'($urandom_range(255)));
   endtask

   task automatic read_bucket(input logic [IDX_W-1:0] index);
      send_item(OP_READ, rand64(), rand64(), index);
   endtask

   task automatic test_directed();
      gap_pct = 0;
      write_bitmap_words(BITMAP_RESET);
      observe(64'h0, '1);
      observe(64'hFF80_0000_0000_0000, '1);
      observe(64'h1, 64'h2);
      observe(64'h1, 64'h2);
      observe(64'hFF80_0000_0000_0001, 64'h2);
      observe(64'h1, ~64'h2);
      observe(64'h1, '1);
      observe(64'(TABLE_DEPTH - 1), 64'h8000_0000_0000_0000);
      observe(64'(TABLE_DEPTH), '1);
      observe(64'h007F_FFFF_FFFF_FFFF, '1);
      observe('1, '1);
      observe(64'd64, 64'h1);
      observe(64'd64, 64'h0);
      read_bucket(8'd0);
      read_bucket(8'd1);
      read_bucket(8'd2);
      read_bucket(8'd3);
      send_item(OP_READ, '1, '1, 8'hFF);
      wait_drained();
   endtask

   task automatic test_bitmap_limit();
      write_bitmap_words(22'd1);
      observe(64'd63, '1);
      observe(64'd64, '1);
      observe(64'd1, '1);
      wait_drained();
      write_bitmap_words('0);
      observe(64'd1, '1);
      observe(64'd0, '1);
      observe(64'd63, '1);
      wait_drained();
      write_bitmap_words(22'd1024);
      observe(64'(TABLE_DEPTH - 1), '1);
      observe(64'(TABLE_DEPTH), '1);
      wait_drained();
      write_bitmap_words(22'd1023);
      observe(64'(TABLE_DEPTH - 1), '1);
      observe(64'(TABLE_DEPTH - 65), '1);
      wait_drained();
      write_bitmap_words(BITMAP_RESET);
   endtask

   task automatic test_age_saturation();
      logic [MAP_W-1:0] word;
      gap_pct = 0;
      for (int i = 0; i < AGE_MAX + 8; i++) begin
         word = rand64();
         word[5] = 1'b1;
         observe({9'($urandom), 55'd5}, word);
         if (i % 64 == 63) read_bucket(IDX_W'(AGE_MAX));
      end
      read_bucket(IDX_W'(AGE_MAX));
      read_bucket(IDX_W'(AGE_MAX - 1));
      observe(64'd5, 64'h0);
      observe(64'd5, 64'h20);
      read_bucket(IDX_W'(AGE_MAX));
      wait_drained();
   endtask

   task automatic random_item();
      int pick;
      logic [FRAME_FIELD_W-1:0] frame;
      logic [MAP_W-1:0] word;
      pick = $urandom_range(99);
      word = rand64();
      if (pick < 15) begin
         read_bucket($urandom_range(1) ? IDX_W'($urandom_range(8)) : IDX_W'($urandom_range(255)));
      end else if (pick < 85) begin
         if (pick < 70) frame = FRAME_FIELD_W'(hot_frames[$urandom_range(11)]);
         else frame = FRAME_FIELD_W'($urandom_range(TABLE_DEPTH - 1, 1));
         word[frame[5:0]] = ($urandom_range(99) < 85);
         observe({9'($urandom), frame}, word);
      end else if (pick < 92) begin
         observe({9'($urandom), 55'd0}, word);
      end else begin
         observe(rand64(), word);
      end
   endtask

   task automatic test_random();
      int pct [4] = '{0, 46, 0, 18};
      logic [BITMAP_W-1:0] limits [4];
      limits = '{BITMAP_RESET, 22'd1024, 22'd16, BITMAP_W'($urandom_range(BITMAP_RESET, 16))};
      foreach (hot_frames[i]) hot_frames[i] = int'($urandom_range(1023, 1));
      for (int p = 0; p < 4; p++) begin
         write_bitmap_words(limits[p]);
         gap_pct = pct[p];
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            random_item();
         end
         wait_drained();
      end
   endtask

   always @(posedge clock) begin
      page_result_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, status %0d age %0d count %0d", $time,
                     rsp_status, rsp_page_age, rsp_bucket_count);
         end else begin
            want = pending_results.pop_front();
            checked++;
            if (rsp_status !== want.status) begin
               errors++;
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
            end
            if (rsp_page_age !== want.page_age) begin
               errors++;
               $display("%0t: page_age expected %0d actual %0d", $time, want.page_age,
                        rsp_page_age);
            end
            if (rsp_bucket_count !== want.count) begin
               errors++;
               $display("%0t: bucket_count expected %0d actual %0d", $time, want.count,
                        rsp_bucket_count);
            end
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_bitmap_limit();
      test_age_saturation();
      test_random();
      $display("testbench: %0d results checked, %0d idle page updates, oldest age %0d",
               checked, idle_updates, oldest_age);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   initial begin
      #6_000_000;
      $display("testbench: done, errors");
      $finish;
   end

endmodule
